// ===== hdl/mtep_pkg.sv =====
// Shared types and constants for the MIDI track event parser.
`timescale 1ns / 1ps

package mtep_pkg;

   // Accumulator width default and reported quantity width
   localparam int QUANTITY_BITS_DEFAULT = 28;
   localparam int REPORT_BITS           = 28;

   // Byte queue between front and back
   localparam int QUEUE_DEPTH    = 4;
   localparam int QUEUE_PTR_BITS = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_BITS = $clog2(QUEUE_DEPTH + 1);

   // Status byte codes
   localparam logic [7:0] STATUS_META  = 8'hFF;
   localparam logic [7:0] STATUS_SYSEX = 8'hF0;
   localparam logic [7:0] STATUS_ESC   = 8'hF7;
   localparam logic [3:0] NIB_PROGRAM  = 4'hC;
   localparam logic [3:0] NIB_PRESSURE = 4'hD;

   // Event kind codes
   localparam logic [1:0] KIND_CHANNEL = 2'd0;
   localparam logic [1:0] KIND_META    = 2'd1;
   localparam logic [1:0] KIND_SYSEX   = 2'd2;

   // One classified byte as it travels through the queue
   typedef struct packed {
      logic [7:0] byte_value;
      logic       chunk_end;
      logic       status_bit;
      logic       is_meta;
      logic       is_sysex;
      logic       one_data;
   } item_type;

   // Queue status seen by the front and the back
   typedef struct packed {
      logic full;
      logic not_empty;
   } queue_status_type;

   // One finished event
   typedef struct packed {
      logic [1:0]             event_kind;
      logic [REPORT_BITS-1:0] delta_ticks;
      logic [7:0]             status_byte;
      logic [7:0]             first_data;
      logic [7:0]             second_data;
      logic [7:0]             meta_kind;
      logic [REPORT_BITS-1:0] payload_length;
      logic [23:0]            meta_value;
      logic                   overlong_flag;
      logic                   truncated_flag;
   } result_type;

endpackage

// ===== hdl/mtep_front.sv =====
// Front end: accepts bytes and classifies them for the parser.
`timescale 1ns / 1ps

module mtep_front
   import mtep_pkg::*;
(
   input  logic             req_valid,
   output logic             req_ready,
   input  logic [7:0]       req_byte_value,
   input  logic             req_chunk_end,
   input  queue_status_type q_status,
   output logic             push,
   output item_type         push_item
);

   // Accept whenever the queue has room
   assign req_ready = !q_status.full;
   assign push      = req_valid && !q_status.full;

   // Classify the byte as a possible status
   always_comb begin
      push_item.byte_value = req_byte_value;
      push_item.chunk_end  = req_chunk_end;
      push_item.status_bit = req_byte_value[7];
      push_item.is_meta    = (req_byte_value == STATUS_META);
      push_item.is_sysex   = (req_byte_value == STATUS_SYSEX) ||
                             (req_byte_value == STATUS_ESC);
      push_item.one_data   = (req_byte_value[7:4] == NIB_PROGRAM) ||
                             (req_byte_value[7:4] == NIB_PRESSURE);
   end

endmodule

// ===== hdl/mtep_queue.sv =====
// Short item queue between the front end and the parser.
`timescale 1ns / 1ps

module mtep_queue
   import mtep_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  item_type         push_item,
   input  logic             pop,
   output item_type         head_item,
   output queue_status_type q_status
);

   item_type                  slot_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_BITS-1:0] count_ff, count_in;

   localparam logic [QUEUE_PTR_BITS-1:0] LAST_PTR = QUEUE_PTR_BITS'(QUEUE_DEPTH - 1);
   localparam logic [QUEUE_CNT_BITS-1:0] FULL_CNT = QUEUE_CNT_BITS'(QUEUE_DEPTH);

   assign head_item          = slot_ff[rd_ptr_ff];
   assign q_status.full      = (count_ff == FULL_CNT);
   assign q_status.not_empty = (count_ff != '0);

   // Advance pointers and count
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store the pushed item
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

// ===== hdl/mtep_back.sv =====
// Back end: event parser state machine and result register.
`timescale 1ns / 1ps

module mtep_back
   import mtep_pkg::*;
#(
   parameter int QUANTITY_BITS = QUANTITY_BITS_DEFAULT
)
(
   input  logic             clock,
   input  logic             reset,
   input  item_type         head_item,
   input  queue_status_type q_status,
   output logic             pop,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output result_type       rsp_result
);

   localparam int QB = QUANTITY_BITS;

   typedef enum logic [6:0] {
      PH_DELTA   = 7'b0000001,
      PH_STATUS  = 7'b0000010,
      PH_DATA1   = 7'b0000100,
      PH_DATA2   = 7'b0001000,
      PH_MTYPE   = 7'b0010000,
      PH_LEN     = 7'b0100000,
      PH_PAYLOAD = 7'b1000000
   } phase_type;

   phase_type        phase_ff, phase_in;
   logic [7:0]       rs_ff, rs_in;
   logic             rs_meta_ff, rs_meta_in;
   logic             rs_sysex_ff, rs_sysex_in;
   logic             rs_one_ff, rs_one_in;
   logic [QB-1:0]    delta_ff, delta_in;
   logic [QB-1:0]    len_ff, len_in;
   logic [2:0]       qcnt_ff, qcnt_in;
   logic [QB-1:0]    remain_ff, remain_in;
   logic [7:0]       held_ff, held_in;
   logic [7:0]       mtype_ff, mtype_in;
   logic [23:0]      cap_ff, cap_in;
   logic [1:0]       seen_ff, seen_in;
   logic             over_ff, over_in;
   logic             rsp_valid_ff, rsp_valid_in;
   result_type       result_ff, result_in;

   logic             consumed, done, emit, known;
   logic [7:0]       second;
   logic [7:0]       b;
   phase_type        ph_eff;
   logic [QB+REPORT_BITS-1:0] delta_wide, len_wide;

   // Saturating count of quantity bytes
   function automatic logic [2:0] count_up(input logic [2:0] c);
      return (c == 3'd7) ? c : c + 3'd1;
   endfunction

   assign b = head_item.byte_value;

   // Parse one byte
   always_comb begin
      phase_in    = phase_ff;
      rs_in       = rs_ff;
      rs_meta_in  = rs_meta_ff;
      rs_sysex_in = rs_sysex_ff;
      rs_one_in   = rs_one_ff;
      delta_in    = delta_ff;
      len_in      = len_ff;
      qcnt_in     = qcnt_ff;
      remain_in   = remain_ff;
      held_in     = held_ff;
      mtype_in    = mtype_ff;
      cap_in      = cap_ff;
      seen_in     = seen_ff;
      over_in     = over_ff;
      consumed    = 1'b0;
      done        = 1'b0;
      second      = '0;
      ph_eff      = phase_ff;

      // Take a new status or apply running status
      if (phase_ff == PH_STATUS) begin
         if (head_item.status_bit) begin
            rs_in       = b;
            rs_meta_in  = head_item.is_meta;
            rs_sysex_in = head_item.is_sysex;
            rs_one_in   = head_item.one_data;
            consumed    = 1'b1;
         end
         if (rs_meta_in) begin
            ph_eff = PH_MTYPE;
         end else if (rs_sysex_in) begin
            ph_eff  = PH_LEN;
            qcnt_in = '0;
            len_in  = '0;
         end else begin
            ph_eff = PH_DATA1;
         end
         phase_in = ph_eff;
      end

      if (!consumed) begin
         case (ph_eff)
            PH_DELTA: begin
               delta_in = {delta_ff[QB-8:0], b[6:0]};
               qcnt_in  = count_up(qcnt_in);
               if (qcnt_in > 3'd4) over_in = 1'b1;
               if (!b[7]) begin
                  phase_in = PH_STATUS;
                  qcnt_in  = '0;
               end
            end
            PH_DATA1: begin
               held_in = b;
               if (rs_one_in) done = 1'b1;
               else phase_in = PH_DATA2;
            end
            PH_DATA2: begin
               second = b;
               done   = 1'b1;
            end
            PH_MTYPE: begin
               mtype_in = b;
               phase_in = PH_LEN;
               qcnt_in  = '0;
               len_in   = '0;
            end
            PH_LEN: begin
               len_in  = {len_in[QB-8:0], b[6:0]};
               qcnt_in = count_up(qcnt_in);
               if (qcnt_in > 3'd4) over_in = 1'b1;
               if (!b[7]) begin
                  remain_in = len_in;
                  if (len_in == '0) done = 1'b1;
                  else phase_in = PH_PAYLOAD;
               end
            end
            PH_PAYLOAD: begin
               // keep the first three payload bytes
               if (seen_ff != 2'd3) begin
                  cap_in  = {cap_ff[15:0], b};
                  seen_in = seen_ff + 2'd1;
               end
               remain_in = remain_ff - {{(QB-1){1'b0}}, 1'b1};
               if (remain_in == '0) done = 1'b1;
            end
            default: begin
               phase_in = PH_DELTA;
            end
         endcase
      end

      emit  = done || head_item.chunk_end;
      known = (phase_in != PH_DELTA) && (phase_in != PH_STATUS);

      // Build the result from the updated state
      delta_wide = {{REPORT_BITS{1'b0}}, delta_in};
      len_wide   = {{REPORT_BITS{1'b0}}, len_in};
      result_in  = '0;
      result_in.delta_ticks    = delta_wide[REPORT_BITS-1:0];
      result_in.overlong_flag  = over_in;
      result_in.truncated_flag = !done;
      if (known) begin
         result_in.status_byte = rs_in;
         if (rs_meta_in) begin
            result_in.event_kind     = KIND_META;
            result_in.meta_kind      = mtype_in;
            result_in.payload_length = len_wide[REPORT_BITS-1:0];
            result_in.meta_value     = cap_in;
         end else if (rs_sysex_in) begin
            result_in.event_kind     = KIND_SYSEX;
            result_in.payload_length = len_wide[REPORT_BITS-1:0];
         end else begin
            result_in.event_kind  = KIND_CHANNEL;
            result_in.first_data  = held_in;
            result_in.second_data = second;
         end
      end

      // Clear the event once it is reported
      if (emit) begin
         phase_in  = PH_DELTA;
         delta_in  = '0;
         len_in    = '0;
         qcnt_in   = '0;
         remain_in = '0;
         held_in   = '0;
         mtype_in  = '0;
         cap_in    = '0;
         seen_in   = '0;
         over_in   = 1'b0;
      end
   end

   // Take the next byte unless a result would have nowhere to go
   assign pop = q_status.not_empty && (!emit || !rsp_valid_ff || rsp_ready);

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (pop && emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_DELTA;
         rs_ff        <= '0;
         rs_meta_ff   <= 1'b0;
         rs_sysex_ff  <= 1'b0;
         rs_one_ff    <= 1'b0;
         delta_ff     <= '0;
         len_ff       <= '0;
         qcnt_ff      <= '0;
         remain_ff    <= '0;
         held_ff      <= '0;
         mtype_ff     <= '0;
         cap_ff       <= '0;
         seen_ff      <= '0;
         over_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (pop) begin
            phase_ff    <= phase_in;
            rs_ff       <= rs_in;
            rs_meta_ff  <= rs_meta_in;
            rs_sysex_ff <= rs_sysex_in;
            rs_one_ff   <= rs_one_in;
            delta_ff    <= delta_in;
            len_ff      <= len_in;
            qcnt_ff     <= qcnt_in;
            remain_ff   <= remain_in;
            held_ff     <= held_in;
            mtype_ff    <= mtype_in;
            cap_ff      <= cap_in;
            seen_ff     <= seen_in;
            over_ff     <= over_in;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Hold the result payload
   always_ff @(posedge clock) begin
      if (pop && emit) begin
         result_ff <= result_in;
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_result = result_ff;

endmodule

// ===== hdl/midi_track_event_parser_unit.sv =====
// Top level of the MIDI track event parser.
//
//   channel | direction | handshake             | payload
//   req     | in        | req_valid / req_ready | byte_value, chunk_end
//   rsp     | out       | rsp_valid / rsp_ready | one finished or truncated event
//
// One byte per cycle sustained unless a result waits on rsp_ready; the parser
// state updates once per byte. The byte that ends an event is registered in a
// queue slot, then its result in the result register.
// Reset is synchronous; there is no clearing pass.
// While a result waits on rsp_ready the parser holds only a byte that would finish
// another event; the four-entry queue keeps it and up to three more bytes.
`timescale 1ns / 1ps

module midi_track_event_parser_unit
   import mtep_pkg::*;
#(
   parameter int QUANTITY_BITS = QUANTITY_BITS_DEFAULT
)
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_byte_value,
   input  logic        req_chunk_end,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_event_kind,
   output logic [27:0] rsp_delta_ticks,
   output logic [7:0]  rsp_status_byte,
   output logic [7:0]  rsp_first_data,
   output logic [7:0]  rsp_second_data,
   output logic [7:0]  rsp_meta_kind,
   output logic [27:0] rsp_payload_length,
   output logic [23:0] rsp_meta_value,
   output logic        rsp_overlong_flag,
   output logic        rsp_truncated_flag
);

   queue_status_type q_status;
   item_type         push_item;
   item_type         head_item;
   logic             push;
   logic             pop;
   result_type       result;

   mtep_front u_front (
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_byte_value (req_byte_value),
      .req_chunk_end  (req_chunk_end),
      .q_status       (q_status),
      .push           (push),
      .push_item      (push_item)
   );

   mtep_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .pop       (pop),
      .head_item (head_item),
      .q_status  (q_status)
   );

   mtep_back #(
      .QUANTITY_BITS (QUANTITY_BITS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .head_item  (head_item),
      .q_status   (q_status),
      .pop        (pop),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_result (result)
   );

   // Spread the result onto its ports
   assign rsp_event_kind     = result.event_kind;
   assign rsp_delta_ticks    = result.delta_ticks;
   assign rsp_status_byte    = result.status_byte;
   assign rsp_first_data     = result.first_data;
   assign rsp_second_data    = result.second_data;
   assign rsp_meta_kind      = result.meta_kind;
   assign rsp_payload_length = result.payload_length;
   assign rsp_meta_value     = result.meta_value;
   assign rsp_overlong_flag  = result.overlong_flag;
   assign rsp_truncated_flag = result.truncated_flag;

endmodule

// ===== test/tb_midi_track_event_parser_unit.sv =====
// Testbench for midi_track_event_parser_unit: directed and random byte streams.
`timescale 1ns / 1ps

module tb_midi_track_event_parser_unit
   import mtep_pkg::*;
();

   localparam int CYCLE_LIMIT = 600000;
   localparam int MAX_WAIT    = 19;

   typedef enum logic [6:0] {
      P_DELTA   = 7'b0000001,
      P_STATUS  = 7'b0000010,
      P_DATA1   = 7'b0000100,
      P_DATA2   = 7'b0001000,
      P_MTYPE   = 7'b0010000,
      P_LEN     = 7'b0100000,
      P_PAYLOAD = 7'b1000000
   } parse_phase_type;

   typedef logic [7:0] byte_seq_type[$];

   logic        clock;
   logic        reset          = 1'b1;
   logic        req_valid      = 1'b0;
   logic        req_ready;
   logic [7:0]  req_byte_value = 8'h00;
   logic        req_chunk_end  = 1'b0;
   logic        rsp_valid;
   logic        rsp_ready      = 1'b0;
   logic [1:0]  rsp_event_kind;
   logic [27:0] rsp_delta_ticks;
   logic [7:0]  rsp_status_byte;
   logic [7:0]  rsp_first_data;
   logic [7:0]  rsp_second_data;
   logic [7:0]  rsp_meta_kind;
   logic [27:0] rsp_payload_length;
   logic [23:0] rsp_meta_value;
   logic        rsp_overlong_flag;
   logic        rsp_truncated_flag;

   // Parser model state
   parse_phase_type ph;
   logic [7:0]   run_status;
   logic [27:0]  delta_acc;
   logic [27:0]  len_acc;
   logic [27:0]  pay_left;
   logic [2:0]   qcount;
   logic [7:0]   data_hold;
   logic [7:0]   mtype_hold;
   logic [23:0]  mvalue;
   logic         long_seen;

   result_type   pending_events[$];
   byte_seq_type event_bytes;
   result_type  want;
   int unsigned stall_left  = 0;
   int unsigned stall_draw;
   int unsigned items_sent  = 0;
   int unsigned fails       = 0;
   int unsigned cycles      = 0;
   bit          steady      = 1'b0;

   midi_track_event_parser_unit u_top (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_byte_value     (req_byte_value),
      .req_chunk_end      (req_chunk_end),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_event_kind     (rsp_event_kind),
      .rsp_delta_ticks    (rsp_delta_ticks),
      .rsp_status_byte    (rsp_status_byte),
      .rsp_first_data     (rsp_first_data),
      .rsp_second_data    (rsp_second_data),
      .rsp_meta_kind      (rsp_meta_kind),
      .rsp_payload_length (rsp_payload_length),
      .rsp_meta_value     (rsp_meta_value),
      .rsp_overlong_flag  (rsp_overlong_flag),
      .rsp_truncated_flag (rsp_truncated_flag)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Drop everything gathered for the current event
   function automatic void clear_event_state();
      ph         = P_DELTA;
      delta_acc  = '0;
      len_acc    = '0;
      qcount     = '0;
      pay_left   = '0;
      data_hold  = '0;
      mtype_hold = '0;
      mvalue     = '0;
      long_seen  = 1'b0;
   endfunction

   // Shift one 7-bit group into a variable-length quantity, keep the low 28 bits
   function automatic logic [27:0] shift_quantity(input logic [27:0] acc, input logic [7:0] b);
      if (qcount < 3'd7) qcount = qcount + 3'd1;
      if (qcount > 3'd4) long_seen = 1'b1;
      return {acc[20:0], b[6:0]};
   endfunction

   // Advance the parser model by one byte; return 1 with the event when one is finished
   function automatic bit parse_byte(input logic [7:0] b, input logic last,
                                     output result_type r);
      bit         taken;
      bit         done;
      bit         known;
      logic [7:0] second;
      logic [7:0] st;
      logic [1:0] kind;
      taken  = 1'b0;
      done   = 1'b0;
      second = 8'h00;
      r      = '0;
      // status position: a byte with bit 7 set becomes the running status
      if (ph == P_STATUS) begin
         if (b[7]) begin
            run_status = b;
            taken      = 1'b1;
         end
         if (run_status == STATUS_META) begin
            ph = P_MTYPE;
         end else if (run_status == STATUS_SYSEX || run_status == STATUS_ESC) begin
            qcount  = '0;
            len_acc = '0;
            ph      = P_LEN;
         end else begin
            ph = P_DATA1;
         end
      end
      if (!taken) begin
         case (ph)
            P_DELTA: begin
               delta_acc = shift_quantity(delta_acc, b);
               if (!b[7]) begin
                  ph     = P_STATUS;
                  qcount = '0;
               end
            end
            P_DATA1: begin
               data_hold = b;
               if (run_status[7:4] == NIB_PROGRAM || run_status[7:4] == NIB_PRESSURE)
                  done = 1'b1;
               else
                  ph = P_DATA2;
            end
            P_DATA2: begin
               second = b;
               done   = 1'b1;
            end
            P_MTYPE: begin
               mtype_hold = b;
               ph         = P_LEN;
               qcount     = '0;
               len_acc    = '0;
            end
            P_LEN: begin
               len_acc = shift_quantity(len_acc, b);
               if (!b[7]) begin
                  pay_left = len_acc;
                  if (pay_left == 28'd0) done = 1'b1;
                  else ph = P_PAYLOAD;
               end
            end
            P_PAYLOAD: begin
               // capture only the first three payload bytes
               if (len_acc - pay_left < 28'd3) mvalue = {mvalue[15:0], b};
               pay_left = pay_left - 28'd1;
               if (pay_left == 28'd0) done = 1'b1;
            end
            default: ph = P_DELTA;
         endcase
      end
      if (!(done || last)) return 1'b0;
      // build the event from what was gathered so far
      known = (ph != P_DELTA) && (ph != P_STATUS);
      st    = known ? run_status : 8'h00;
      kind  = KIND_CHANNEL;
      if (known && st == STATUS_META)
         kind = KIND_META;
      else if (known && (st == STATUS_SYSEX || st == STATUS_ESC))
         kind = KIND_SYSEX;
      r.event_kind  = kind;
      r.delta_ticks = delta_acc;
      r.status_byte = st;
      if (known && kind == KIND_CHANNEL) begin
         r.first_data  = data_hold;
         r.second_data = second;
      end
      if (kind == KIND_META) begin
         r.meta_kind  = mtype_hold;
         r.meta_value = mvalue;
      end
      if (kind != KIND_CHANNEL) r.payload_length = len_acc;
      r.overlong_flag  = long_seen;
      r.truncated_flag = !done;
      clear_event_state();
      return 1'b1;
   endfunction

   // Send one item after a random gap and record the event it finishes
   task automatic send_byte(input logic [7:0] b, input logic last);
      result_type  r;
      int unsigned gap;
      gap = steady ? 0 : $urandom_range(0, MAX_WAIT);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_byte_value <= b;
      req_chunk_end  <= last;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      if (parse_byte(b, last, r)) pending_events.push_back(r);
      items_sent++;
   endtask

   // Send a fixed sequence, optionally ending the chunk on its last byte
   task automatic send_bytes(input byte_seq_type seq, input bit cut_at_end);
      for (int i = 0; i < seq.size(); i++)
         send_byte(seq[i], cut_at_end && (i == seq.size() - 1));
   endtask

   // Hold input idle until every pending event has come out
   task automatic wait_events_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_events.size() != 0) @(posedge clock);
   endtask

   // Append a variable-length length field and its payload
   task automatic add_length_and_payload();
      int unsigned plen;
      int unsigned n;
      logic [7:0]  b;
      plen = ($urandom_range(0, 19) == 0) ? $urandom_range(9, 40) : $urandom_range(0, 6);
      n    = ($urandom_range(0, 9) == 0) ? $urandom_range(2, 6) : 1;
      // pad with leading zero groups so long quantities stay small
      for (int i = n - 1; i >= 0; i--) begin
         b    = 8'((plen >> (7 * i)) & 32'h7f);
         b[7] = (i != 0);
         event_bytes.push_back(b);
      end
      repeat (plen) event_bytes.push_back(8'($urandom_range(0, 255)));
   endtask

   // Compose one well-formed event with random content
   task automatic compose_event();
      int unsigned n;
      logic [7:0]  b;
      logic [7:0]  st;
      event_bytes.delete();
      n = ($urandom_range(0, 15) == 0) ? $urandom_range(5, 6) : $urandom_range(1, 4);
      for (int i = n - 1; i >= 0; i--) begin
         b    = 8'($urandom_range(0, 127));
         b[7] = (i != 0);
         event_bytes.push_back(b);
      end
      // explicit status most of the time, otherwise running status
      if ($urandom_range(0, 3) != 0) begin
         case ($urandom_range(0, 5))
            0:       st = STATUS_META;
            1:       st = $urandom_range(0, 1) ? STATUS_SYSEX : STATUS_ESC;
            default: st = 8'($urandom_range(128, 254));
         endcase
         event_bytes.push_back(st);
      end else begin
         st = run_status;
      end
      if (st == STATUS_META) begin
         event_bytes.push_back(8'($urandom_range(0, 255)));
         add_length_and_payload();
      end else if (st == STATUS_SYSEX || st == STATUS_ESC) begin
         add_length_and_payload();
      end else begin
         repeat ((st[7:4] == NIB_PROGRAM || st[7:4] == NIB_PRESSURE) ? 1 : 2) begin
            b = ($urandom_range(0, 7) == 0) ? 8'($urandom_range(0, 255))
                                            : 8'($urandom_range(0, 127));
            event_bytes.push_back(b);
         end
      end
   endtask

   task automatic test_channel_messages();
      // running status still zero: two data bytes, status 0
      send_bytes('{8'h00, 8'h12, 8'h34}, 1'b0);
      // largest four-byte delta, note on with data bytes that have bit 7 set
      send_bytes('{8'hFF, 8'hFF, 8'hFF, 8'h7F, 8'h90, 8'h80, 8'hFF}, 1'b0);
   endtask

   task automatic test_meta_and_sysex();
      // tempo meta event
      send_bytes('{8'h00, 8'hFF, 8'h51, 8'h03, 8'h07, 8'hA1, 8'h20}, 1'b0);
      // five-byte delta, then a zero-length sysex
      send_bytes('{8'h81, 8'h80, 8'h80, 8'h80, 8'h00, 8'hF7, 8'h00}, 1'b0);
      // sysex status kept as running status
      send_bytes('{8'h00, 8'h00}, 1'b0);
   endtask

   task automatic test_chunk_cut();
      // meta event of type FF with a two-byte length, cut inside the payload
      send_bytes('{8'h00, 8'hFF, 8'hFF, 8'hFF, 8'h7F, 8'h5A}, 1'b1);
      // cut right at the status byte; running status carries to the next chunk
      send_bytes('{8'h05, 8'hFF}, 1'b1);
   endtask

   task automatic test_random_events();
      int          cut;
      int unsigned last_index;
      while (items_sent < 930) begin
         if ($urandom_range(0, 39) == 0) steady = !steady;
         compose_event();
         cut = -1;
         if ($urandom_range(0, 9) == 0)
            cut = int'($urandom_range(0, event_bytes.size() - 1));
         else if ($urandom_range(0, 7) == 0)
            cut = event_bytes.size() - 1;
         last_index = (cut >= 0) ? cut : event_bytes.size() - 1;
         for (int i = 0; i <= last_index; i++)
            send_byte(event_bytes[i], i == cut);
      end
      steady = 1'b0;
   endtask

   task automatic test_random_noise();
      repeat (150) send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 15) == 0);
   endtask

   // Report one field that differs from the prediction
   task automatic check_field(input string name, input logic [27:0] exp_v,
                              input logic [27:0] act_v);
      if (exp_v !== act_v) begin
         $error("%s: expected 0x%0h, got 0x%0h", name, exp_v, act_v);
         fails++;
      end
   endtask

   // Check each accepted result and stall the result side at random
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready  <= 1'b0;
         stall_left <= 0;
      end else if (rsp_valid && rsp_ready) begin
         if (pending_events.size() == 0) begin
            $error("result with no event pending");
            fails++;
         end else begin
            want = pending_events.pop_front();
            check_field("event_kind",     28'(want.event_kind),     28'(rsp_event_kind));
            check_field("delta_ticks",    want.delta_ticks,         rsp_delta_ticks);
            check_field("status_byte",    28'(want.status_byte),    28'(rsp_status_byte));
            check_field("first_data",     28'(want.first_data),     28'(rsp_first_data));
            check_field("second_data",    28'(want.second_data),    28'(rsp_second_data));
            check_field("meta_kind",      28'(want.meta_kind),      28'(rsp_meta_kind));
            check_field("payload_length", want.payload_length,      rsp_payload_length);
            check_field("meta_value",     28'(want.meta_value),     28'(rsp_meta_value));
            check_field("overlong_flag",  28'(want.overlong_flag),  28'(rsp_overlong_flag));
            check_field("truncated_flag", 28'(want.truncated_flag), 28'(rsp_truncated_flag));
         end
         stall_draw = steady ? 0 : $urandom_range(0, MAX_WAIT);
         stall_left <= stall_draw;
         rsp_ready  <= (stall_draw == 0);
      end else if (stall_left > 1) begin
         stall_left <= stall_left - 1;
      end else begin
         stall_left <= 0;
         rsp_ready  <= 1'b1;
      end
   end

   // Stop a hung run
   always @(posedge clock) begin
      cycles++;
      if (cycles == CYCLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   initial begin
      run_status = 8'h00;
      clear_event_state();
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      test_channel_messages();
      test_meta_and_sysex();
      test_chunk_cut();
      wait_events_drained();
      test_random_events();
      test_random_noise();
      wait_events_drained();
      repeat (8) @(posedge clock);
      if (fails == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule

// ===== files.f =====
hdl/mtep_pkg.sv
hdl/mtep_front.sv
hdl/mtep_queue.sv
hdl/mtep_back.sv
hdl/midi_track_event_parser_unit.sv
test/tb_midi_track_event_parser_unit.sv
